FILE: hdl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// next-cycle implication
`define SWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

FILE: hdl/swm_pkg.sv
`default_nettype none

package swm_pkg;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_retire;
		logic retire;
		logic rd_tail;
		logic pop;
		logic append;
		logic rd_head;
		logic load_out;
	} swm_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic q_empty;
		logic q_one;
		logic tail_less;
		logic win_full;
		logic out_free;
	} swm_sts_t;

endpackage

`default_nettype wire

FILE: hdl/swm_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module swm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire swm_pkg::swm_sts_t sts,
	output swm_pkg::swm_cmd_t     cmd
);
	import swm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_POP  = 3'd3;
	localparam logic [2:0] S_APP  = 3'd4;
	localparam logic [2:0] S_HRD  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_retire = 1'b1;
				state_d       = S_CMP;
			end
			S_CMP: begin
				// tail address is unaffected by a head drop
				cmd.retire  = 1'b1;
				cmd.rd_tail = 1'b1;
				state_d     = S_POP;
			end
			S_POP: begin
				if (sts.q_empty) begin
					state_d = S_APP;
				end else if (sts.tail_less) begin
					cmd.pop     = 1'b1;
					cmd.rd_tail = 1'b1;
					if (sts.q_one) begin
						state_d = S_APP;
					end
				end else begin
					state_d = S_APP;
				end
			end
			S_APP: begin
				cmd.append = 1'b1;
				state_d    = S_HRD;
			end
			S_HRD: begin
				cmd.rd_head = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (!sts.win_full) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SWM_ASSERT_NXT(a_accept_to_rd, clk, arst_n, cmd.accept, state_q == S_RD)
	`SWM_ASSERT_IMP(a_pop_nonempty, clk, arst_n, cmd.pop, !sts.q_empty)
	`SWM_ASSERT_IMP(a_state_legal, clk, arst_n, 1'b1, state_q <= S_EMIT)

endmodule

`default_nettype wire

FILE: hdl/swm_dpath.sv
`default_nettype none
`include "assert_macros.svh"

module swm_dpath #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32,
	parameter int AW           = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
	parameter int CW           = $clog2(WINDOW_MAX + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire swm_pkg::swm_cmd_t        cmd,
	output swm_pkg::swm_sts_t             sts,
	input  wire logic                     cfg_wen,
	input  wire logic [CW-1:0]            cfg_wdata,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic                     first,
	input  wire logic                     out_ready,
	output logic                          out_valid,
	output logic signed [SAMPLE_WIDTH-1:0] window_max
);
	import swm_pkg::*;

	localparam logic [AW:0]   WM_A = (AW + 1)'(WINDOW_MAX);
	localparam logic [CW-1:0] WM_C = CW'(WINDOW_MAX);

	function automatic logic [AW-1:0] qwrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= WM_A) begin
			s = s - WM_A;
		end
		return s[AW-1:0];
	endfunction

	logic [CW-1:0] ws_q;
	logic [CW-1:0] qc_q;
	logic [CW-1:0] seen_q;
	logic [AW-1:0] hp_q;
	logic [AW-1:0] wp_q;
	logic          out_valid_q;

	logic [SAMPLE_WIDTH-1:0] samp_q;
	logic [SAMPLE_WIDTH-1:0] out_data_q;
	logic [SAMPLE_WIDTH-1:0] hist_rd_q;
	logic [SAMPLE_WIDTH-1:0] qa_rd_q;
	logic [SAMPLE_WIDTH-1:0] qb_rd_q;

	logic [SAMPLE_WIDTH-1:0] hist_mem [WINDOW_MAX];
	logic [SAMPLE_WIDTH-1:0] queue_mem [WINDOW_MAX];

	logic [CW-1:0] ws_eff;
	logic [CW-1:0] back_off;
	logic [CW-1:0] tail_off;
	logic [AW-1:0] slot;
	logic [AW-1:0] tail_addr;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] hp_inc;
	logic [AW-1:0] wp_inc;
	logic          win_full;
	logic          q_full;
	logic          retire_hit;

	always_comb begin
		if (ws_q == '0) begin
			ws_eff = CW'(1);
		end else if (ws_q > WM_C) begin
			ws_eff = WM_C;
		end else begin
			ws_eff = ws_q;
		end
	end

	assign back_off   = WM_C - ws_eff;
	assign slot       = qwrap(wp_q, back_off[AW-1:0]);
	// after a pop the next tail sits one entry further in
	assign tail_off   = qc_q - CW'(1) - CW'(cmd.pop);
	assign tail_addr  = qwrap(hp_q, tail_off[AW-1:0]);
	assign q_full     = (qc_q == WM_C);
	assign wr_addr    = q_full ? hp_q : qwrap(hp_q, qc_q[AW-1:0]);
	assign hp_inc     = qwrap(hp_q, AW'(1));
	assign wp_inc     = qwrap(wp_q, AW'(1));
	assign win_full   = (seen_q >= ws_eff);
	assign retire_hit = win_full && (qc_q != '0) && (qa_rd_q == hist_rd_q);

	assign sts.q_empty   = (qc_q == '0);
	assign sts.q_one     = (qc_q == CW'(1));
	assign sts.tail_less = ($signed(qb_rd_q) < $signed(samp_q));
	assign sts.win_full  = win_full;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			hist_mem[wp_q] <= samp_q;
		end
		if (cmd.rd_retire) begin
			hist_rd_q <= hist_mem[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			queue_mem[wr_addr] <= samp_q;
		end
		if (cmd.rd_retire || cmd.rd_head) begin
			qa_rd_q <= queue_mem[hp_q];
		end
		if (cmd.rd_tail) begin
			qb_rd_q <= queue_mem[tail_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			samp_q <= sample;
		end
		if (cmd.load_out) begin
			out_data_q <= qa_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= CW'(1);
			qc_q        <= '0;
			seen_q      <= '0;
			hp_q        <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				ws_q   <= cfg_wdata;
				qc_q   <= '0;
				seen_q <= '0;
				wp_q   <= '0;
			end
			if (cmd.accept && first) begin
				qc_q   <= '0;
				seen_q <= '0;
				wp_q   <= '0;
			end
			if (cmd.retire && retire_hit) begin
				hp_q <= hp_inc;
				qc_q <= qc_q - CW'(1);
			end
			if (cmd.pop) begin
				qc_q <= qc_q - CW'(1);
			end
			if (cmd.append) begin
				// a full queue drops its head to make room
				if (q_full) begin
					hp_q <= hp_inc;
				end else begin
					qc_q <= qc_q + CW'(1);
				end
				wp_q <= wp_inc;
				if (seen_q < ws_eff) begin
					seen_q <= seen_q + CW'(1);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = $signed(out_data_q);

	`SWM_ASSERT_IMP(a_qc_bound, clk, arst_n, 1'b1, qc_q <= WM_C)
	`SWM_ASSERT_IMP(a_seen_bound, clk, arst_n, 1'b1, seen_q <= ws_eff)
	`SWM_ASSERT_IMP(a_load_free, clk, arst_n, cmd.load_out, !out_valid_q || out_ready)

endmodule

`default_nettype wire

FILE: hdl/sliding_window_maximum.sv
// a beat steps from accept through history read, retire compare, tail evictions (the
// eviction loop reads one tail per cycle), append, head read and emit; throughput: one beat
// at a time; the next is taken once the result is registered or skipped (window not full)
// the result register lets a new beat in while the previous result waits for out_ready
// reset: arst_n clears the window (window_size = 1) and all counters; memories keep garbage
`default_nettype none

module sliding_window_maximum #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wen,
	input  wire logic [$clog2(WINDOW_MAX + 1)-1:0]      cfg_wdata,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]         sample,
	input  wire logic                                   first,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]              window_max
);
	import swm_pkg::*;

	swm_cmd_t cmd;
	swm_sts_t sts;

	swm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swm_dpath #(
		.WINDOW_MAX   (WINDOW_MAX),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.sample     (sample),
		.first      (first),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.window_max (window_max)
	);

endmodule

`default_nettype wire
